[src/rgb2hsl_pkg.sv]
// Shared types and constants for the RGB to HSL converter.
`timescale 1ns / 1ps

package rgb2hsl_pkg;

   localparam int CHAN_W          = 8;
   localparam int HUE_W           = 9;
   localparam int CHAN_MAX        = 255;
   localparam int HUE_WRAP        = 360;
   localparam int HUE_MAX         = 359;
   localparam int HUE_SCALE       = 60;
   localparam int HUE_BASE_GREEN  = 120;
   localparam int HUE_BASE_BLUE   = 240;
   // both quotients stay below 2**CHAN_W, so CHAN_W restoring steps suffice
   localparam int DIV_STEPS       = CHAN_W;
   localparam int STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES      = DIV_STEPS / STEPS_PER_STAGE;
   // accept edge to result edge: extremum stage, load stage, divider, output register
   localparam int LATENCY         = DIV_STAGES + 3;

   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } sector_type;

   // one divider stage: saturation and hue dividers run side by side
   typedef struct packed {
      logic                grey;
      logic                neg;
      sector_type          sector;
      logic [CHAN_W-1:0]   light;
      logic [CHAN_W-1:0]   dvs_s;
      logic [CHAN_W-1:0]   rem_s;
      logic [CHAN_W-1:0]   lo_s;
      logic [CHAN_W-1:0]   dvs_h;
      logic [CHAN_W-1:0]   rem_h;
      logic [CHAN_W-1:0]   lo_h;
   } div_stage_type;

endpackage

[src/rgb_to_hsl_converter_unit.sv]
// RGB to HSL converter: pipelined top level.
// Usage:
//   Input channel: drive req_red, req_green, req_blue and raise start. A beat
//   is taken at each rising edge where start is high and busy is low. busy
//   is high only during reset, so one pixel per clock can be fed.
//   Result channel: rsp_strobe is high for exactly one cycle with rsp_hue,
//   rsp_saturation and rsp_lightness valid; the beat is taken at the edge
//   that ends that cycle.
// Throughput: one pixel per cycle while reset is low.
// Pipeline: extremum/sector stage, scaling stage (delta*255 and 60*diff),
//   four stages of a radix-2 restoring divider pair with two quotient bits
//   each, then the hue assembly and output register. The divider depth
//   sets the latency.
// Reset: synchronous, clears all valid bits; in-flight pixels are dropped
//   and no stray result is shown.
// Stall: the receiver cannot hold results off; nothing stalls, and results
//   leave in acceptance order.
`timescale 1ns / 1ps

module rgb_to_hsl_converter_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [rgb2hsl_pkg::CHAN_W-1:0]    req_red,
   input  logic [rgb2hsl_pkg::CHAN_W-1:0]    req_green,
   input  logic [rgb2hsl_pkg::CHAN_W-1:0]    req_blue,
   output logic                              rsp_strobe,
   output logic [rgb2hsl_pkg::HUE_W-1:0]     rsp_hue,
   output logic [rgb2hsl_pkg::CHAN_W-1:0]    rsp_saturation,
   output logic [rgb2hsl_pkg::CHAN_W-1:0]    rsp_lightness
);

   localparam int W  = rgb2hsl_pkg::CHAN_W;
   localparam int NS = rgb2hsl_pkg::DIV_STAGES;

   // restoring step: returns {remainder, shifted low word with quotient bit}
   function automatic logic [2*W-1:0] div_step(input logic [W-1:0] rem,
                                                input logic [W-1:0] lo,
                                                input logic [W-1:0] dvs);
      logic [W:0] t;
      logic       q;
      t = {rem, lo[W-1]};
      q = (t >= {1'b0, dvs});
      if (q) begin
         t = t - {1'b0, dvs};
      end
      return {t[W-1:0], lo[W-2:0], q};
   endfunction

   logic accept;
   assign busy   = reset;
   assign accept = start && !busy;

   // ---------------- stage 1: extremes and sector ----------------
   logic                    s1_vld_ff;
   rgb2hsl_pkg::sector_type s1_sector_ff, s1_sector_in;
   logic                    s1_neg_ff, s1_neg_in;
   logic [W-1:0]            s1_mag_ff, s1_mag_in;
   logic [W-1:0]            s1_delta_ff, s1_delta_in;
   logic [W:0]              s1_sum_ff, s1_sum_in;
   logic [W-1:0]            mx, mn, sa, sc;

   always_comb begin
      if (req_red >= req_green && req_red >= req_blue) begin
         s1_sector_in = rgb2hsl_pkg::SECT_RED;
         mx = req_red;
         sa = req_green;
         sc = req_blue;
      end else if (req_green >= req_blue) begin
         s1_sector_in = rgb2hsl_pkg::SECT_GREEN;
         mx = req_green;
         sa = req_blue;
         sc = req_red;
      end else begin
         s1_sector_in = rgb2hsl_pkg::SECT_BLUE;
         mx = req_blue;
         sa = req_red;
         sc = req_green;
      end
      mn = req_red;
      if (req_green < mn) begin
         mn = req_green;
      end
      if (req_blue < mn) begin
         mn = req_blue;
      end
      s1_neg_in   = (sa < sc);
      s1_mag_in   = s1_neg_in ? (sc - sa) : (sa - sc);
      s1_delta_in = mx - mn;
      s1_sum_in   = {1'b0, mx} + {1'b0, mn};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_sector_ff <= s1_sector_in;
      s1_neg_ff    <= s1_neg_in;
      s1_mag_ff    <= s1_mag_in;
      s1_delta_ff  <= s1_delta_in;
      s1_sum_ff    <= s1_sum_in;
   end

   // ---------------- stage 2: scaling, divider load ----------------
   logic                       vld_ff [0:NS];
   rgb2hsl_pkg::div_stage_type pipe_ff [0:NS];
   rgb2hsl_pkg::div_stage_type pipe_in [0:NS];
   logic [W:0]                 spread;
   logic [2*W-1:0]             num_s, num_h;

   always_comb begin
      rgb2hsl_pkg::div_stage_type cur;
      spread = (s1_sum_ff >= (W+1)'(rgb2hsl_pkg::CHAN_MAX))
             ? (s1_sum_ff - (W+1)'(rgb2hsl_pkg::CHAN_MAX))
             : ((W+1)'(rgb2hsl_pkg::CHAN_MAX) - s1_sum_ff);
      // delta*255 and 60*mag as shift-and-subtract
      num_s = {s1_delta_ff, {W{1'b0}}} - {{W{1'b0}}, s1_delta_ff};
      num_h = ({{W{1'b0}}, s1_mag_ff} << 6) - ({{W{1'b0}}, s1_mag_ff} << 2);
      pipe_in[0].grey   = (s1_delta_ff == '0);
      pipe_in[0].neg    = s1_neg_ff;
      pipe_in[0].sector = s1_sector_ff;
      pipe_in[0].light  = s1_sum_ff[W:1];
      pipe_in[0].dvs_s  = W'((W+1)'(rgb2hsl_pkg::CHAN_MAX) - spread);
      pipe_in[0].rem_s  = num_s[2*W-1:W];
      pipe_in[0].lo_s   = num_s[W-1:0];
      pipe_in[0].dvs_h  = s1_delta_ff;
      pipe_in[0].rem_h  = num_h[2*W-1:W];
      pipe_in[0].lo_h   = num_h[W-1:0];

      // ---------------- divider stages ----------------
      for (int k = 1; k <= NS; k++) begin
         cur = pipe_ff[k-1];
         for (int j = 0; j < rgb2hsl_pkg::STEPS_PER_STAGE; j++) begin
            {cur.rem_s, cur.lo_s} = div_step(cur.rem_s, cur.lo_s, cur.dvs_s);
            {cur.rem_h, cur.lo_h} = div_step(cur.rem_h, cur.lo_h, cur.dvs_h);
         end
         pipe_in[k] = cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NS; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= s1_vld_ff;
         for (int k = 1; k <= NS; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= NS; k++) begin
         pipe_ff[k] <= pipe_in[k];
      end
   end

   // ---------------- output stage: hue assembly ----------------
   rgb2hsl_pkg::div_stage_type fin;
   logic [rgb2hsl_pkg::HUE_W:0]   base, up, hsum;
   logic [rgb2hsl_pkg::HUE_W-1:0] rsp_hue_ff, rsp_hue_in;
   logic [W-1:0]                  rsp_sat_ff, rsp_sat_in;
   logic [W-1:0]                  rsp_light_ff;
   logic                          rsp_strobe_ff;

   assign fin = pipe_ff[NS];

   always_comb begin
      case (fin.sector)
         rgb2hsl_pkg::SECT_RED:   base = '0;
         rgb2hsl_pkg::SECT_GREEN: base = (rgb2hsl_pkg::HUE_W+1)'(rgb2hsl_pkg::HUE_BASE_GREEN);
         rgb2hsl_pkg::SECT_BLUE:  base = (rgb2hsl_pkg::HUE_W+1)'(rgb2hsl_pkg::HUE_BASE_BLUE);
         default:                 base = '0;
      endcase
      // negative offset: subtract the ceiling of the quotient
      up   = (rgb2hsl_pkg::HUE_W+1)'(fin.lo_h) + (rgb2hsl_pkg::HUE_W+1)'(fin.rem_h != '0);
      hsum = fin.neg
           ? (base + (rgb2hsl_pkg::HUE_W+1)'(rgb2hsl_pkg::HUE_WRAP) - up)
           : (base + (rgb2hsl_pkg::HUE_W+1)'(fin.lo_h));
      if (hsum >= (rgb2hsl_pkg::HUE_W+1)'(rgb2hsl_pkg::HUE_WRAP)) begin
         hsum = hsum - (rgb2hsl_pkg::HUE_W+1)'(rgb2hsl_pkg::HUE_WRAP);
      end
      rsp_hue_in = fin.grey ? '0 : hsum[rgb2hsl_pkg::HUE_W-1:0];
      rsp_sat_in = fin.grey ? '0 : fin.lo_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= vld_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      rsp_hue_ff   <= rsp_hue_in;
      rsp_sat_ff   <= rsp_sat_in;
      rsp_light_ff <= fin.light;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_hue        = rsp_hue_ff;
   assign rsp_saturation = rsp_sat_ff;
   assign rsp_lightness  = rsp_light_ff;

endmodule

[src/rgb2hsl_checker.sv]
// Port-level checker for the RGB to HSL converter, bound to the top level.
`timescale 1ns / 1ps

module rgb2hsl_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_strobe,
   input logic [rgb2hsl_pkg::HUE_W-1:0]     rsp_hue,
   input logic [rgb2hsl_pkg::CHAN_W-1:0]    rsp_saturation
);

   logic accept;
   assign accept = start && !busy;

   // every beat taken comes out as a result strobe
   a_beat_out: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(rgb2hsl_pkg::LATENCY) rsp_strobe)
      else $error("accepted beat produced no result");

   // no result without a matching beat
   a_no_stray: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, rgb2hsl_pkg::LATENCY))
      else $error("result without accepted beat");

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_hue <= rgb2hsl_pkg::HUE_WRAP - 1))
      else $error("hue out of range");

   // a nonzero hue means a colored pixel, which always has some saturation
   a_hue_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_hue != '0) |-> (rsp_saturation != '0))
      else $error("hue set on a grey result");

endmodule

bind rgb_to_hsl_converter_unit rgb2hsl_checker u_rgb2hsl_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_hue        (rsp_hue),
   .rsp_saturation (rsp_saturation)
);

[sim/rgb_to_hsl_converter_unit_tb.sv]
// Self-checking testbench for the RGB to HSL converter pipeline.
`timescale 1ns / 1ps

module rgb_to_hsl_converter_unit_tb;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int CHAN_W         = rgb2hsl_pkg::CHAN_W;
   localparam int HUE_W          = rgb2hsl_pkg::HUE_W;
   localparam int CHAN_MAX       = rgb2hsl_pkg::CHAN_MAX;
   localparam int HUE_WRAP       = rgb2hsl_pkg::HUE_WRAP;
   localparam int HUE_SCALE      = rgb2hsl_pkg::HUE_SCALE;
   localparam int HUE_BASE_GREEN = rgb2hsl_pkg::HUE_BASE_GREEN;
   localparam int HUE_BASE_BLUE  = rgb2hsl_pkg::HUE_BASE_BLUE;
   localparam int LATENCY        = rgb2hsl_pkg::LATENCY;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [CHAN_W-1:0] sat;
      logic [CHAN_W-1:0] light;
   } hsl_beat_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic [CHAN_W-1:0] req_red = '0;
   logic [CHAN_W-1:0] req_green = '0;
   logic [CHAN_W-1:0] req_blue = '0;
   logic              busy;
   logic              rsp_strobe;
   logic [HUE_W-1:0]  rsp_hue;
   logic [CHAN_W-1:0] rsp_saturation;
   logic [CHAN_W-1:0] rsp_lightness;

   hsl_beat_type pending_hsl[$];
   hsl_beat_type want_beat;
   int           idle_pct = 0;
   int           error_count = 0;
   int           pixels_sent = 0;
   int           beats_checked = 0;
   int           grey_sent = 0;
   int unsigned  cycle_count = 0;

   rgb_to_hsl_converter_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_strobe     (rsp_strobe),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_lightness  (rsp_lightness)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, pending_hsl.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // floor(base + 60*(a-c)/d), wrapped into 0..359
   function automatic int unsigned sector_hue(int unsigned base, int unsigned a,
                                              int unsigned c, int unsigned d);
      int unsigned t;
      if (a >= c) begin
         t = base + (HUE_SCALE * (a - c)) / d;
      end else begin
         // negative offset: floor of a negative quotient is minus its ceiling
         t = base + HUE_WRAP - (HUE_SCALE * (c - a) + d - 1) / d;
      end
      if (t >= HUE_WRAP) begin
         t = t - HUE_WRAP;
      end
      return t;
   endfunction

   function automatic hsl_beat_type predict_hsl(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                                logic [CHAN_W-1:0] b);
      int unsigned             mx, mn, delta, chan_sum, spread, sat, hue;
      rgb2hsl_pkg::sector_type sect;
      hsl_beat_type            res;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      delta = mx - mn;
      chan_sum = mx + mn;
      sat = 0;
      hue = 0;
      // ties for the maximum go to red, then green
      if (mx == r) sect = rgb2hsl_pkg::SECT_RED;
      else if (mx == g) sect = rgb2hsl_pkg::SECT_GREEN;
      else sect = rgb2hsl_pkg::SECT_BLUE;
      if (delta != 0) begin
         spread = (chan_sum >= CHAN_MAX) ? chan_sum - CHAN_MAX : CHAN_MAX - chan_sum;
         sat = (delta * CHAN_MAX) / (CHAN_MAX - spread);
         if (sat > CHAN_MAX) sat = CHAN_MAX;
         case (sect)
            rgb2hsl_pkg::SECT_RED: begin
               hue = sector_hue(0, g, b, delta);
            end
            rgb2hsl_pkg::SECT_GREEN: begin
               hue = sector_hue(HUE_BASE_GREEN, b, r, delta);
            end
            default: begin
               hue = sector_hue(HUE_BASE_BLUE, r, g, delta);
            end
         endcase
      end
      res.hue = hue[HUE_W-1:0];
      res.sat = sat[CHAN_W-1:0];
      res.light = chan_sum[CHAN_W:1];
      return res;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_hsl.size() == 0) begin
            $display("%0t: unexpected result beat hue=%0d sat=%0d light=%0d", $time,
                     rsp_hue, rsp_saturation, rsp_lightness);
            error_count++;
         end else begin
            want_beat = pending_hsl.pop_front();
            beats_checked++;
            if (rsp_hue !== want_beat.hue) begin
               $display("%0t: hue expected %0d actual %0d", $time, want_beat.hue, rsp_hue);
               error_count++;
            end
            if (rsp_saturation !== want_beat.sat) begin
               $display("%0t: saturation expected %0d actual %0d", $time, want_beat.sat,
                        rsp_saturation);
               error_count++;
            end
            if (rsp_lightness !== want_beat.light) begin
               $display("%0t: lightness expected %0d actual %0d", $time, want_beat.light,
                        rsp_lightness);
               error_count++;
            end
         end
      end
   end

   // Leaves start high after the accepting edge so back-to-back beats stay gapless.
   task automatic send_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                             logic [CHAN_W-1:0] b);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         req_red <= CHAN_W'($urandom);
         req_green <= CHAN_W'($urandom);
         req_blue <= CHAN_W'($urandom);
         @(posedge clock);
      end
      start <= 1'b1;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      do @(posedge clock); while (busy);
      pending_hsl.push_back(predict_hsl(r, g, b));
      pixels_sent++;
      if (r == g && g == b) grey_sent++;
   endtask

   // always advances at least one edge, so start never gets two updates in one step
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending_hsl.size() != 0);
   endtask

   task automatic test_extremes();
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd1, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd1);
      send_pixel(8'd255, 8'd254, 8'd254);
      send_pixel(8'd128, 8'd127, 8'd127);
      send_pixel(8'd0, 8'd255, 8'd1);
   endtask

   task automatic test_primaries();
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd170, 8'd85, 8'd0);
   endtask

   task automatic test_ties_and_wrap();
      send_pixel(8'd200, 8'd200, 8'd50);
      send_pixel(8'd10, 8'd200, 8'd200);
      send_pixel(8'd90, 8'd30, 8'd90);
      // red max with blue above green: hue goes negative and wraps
      send_pixel(8'd255, 8'd0, 8'd1);
      send_pixel(8'd200, 8'd3, 8'd100);
      send_pixel(8'd7, 8'd5, 8'd6);
      send_pixel(8'd254, 8'd253, 8'd255);
   endtask

   task automatic test_random(int count, int pct);
      logic [CHAN_W-1:0] r, g, b, base;
      int unsigned       kind;
      idle_pct = pct;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(9);
         r = CHAN_W'($urandom);
         g = CHAN_W'($urandom);
         b = CHAN_W'($urandom);
         if (kind >= 6 && kind <= 7) begin
            // near-grey: small delta stresses the divider and the hue sectors
            base = CHAN_W'($urandom_range(4, 251));
            r = base + CHAN_W'($urandom_range(4)) - 8'd2;
            g = base + CHAN_W'($urandom_range(4)) - 8'd2;
            b = base + CHAN_W'($urandom_range(4)) - 8'd2;
         end else if (kind == 8) begin
            case ($urandom_range(2))
               0: g = r;
               1: b = g;
               default: b = r;
            endcase
         end else if (kind == 9) begin
            case ($urandom_range(3))
               0: begin g = r; b = r; end
               1: r = ($urandom_range(1)) ? 8'd255 : 8'd0;
               2: g = ($urandom_range(1)) ? 8'd255 : 8'd0;
               default: b = ($urandom_range(1)) ? 8'd255 : 8'd0;
            endcase
         end
         send_pixel(r, g, b);
      end
   endtask

   task automatic test_pause_until_drained();
      idle_pct = 0;
      for (int i = 0; i < 4; i++) begin
         send_pixel(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
         send_pixel(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
         wait_drained();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_primaries();
      test_ties_and_wrap();
      test_random(150, 0);
      test_pause_until_drained();
      test_random(150, 60);
      test_random(150, 16);
      test_random(150, 0);
      wait_drained();
      repeat (LATENCY + 4) @(posedge clock);
      $display("Converted %0d pixels (%0d grey), %0d results checked, gapless and gappy feeds.",
               pixels_sent, grey_sent, beats_checked);
      $display("Directed extremes, primaries, max ties and negative red hue ran before random.");
      if (error_count == 0 && pending_hsl.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
